FILE: rtl/core/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Short forms for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared widths, codes, payload structs and controller/datapath links.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths of the item and result transfers
    localparam int MODE_W       = 2;
    localparam int CHAR_W       = 8;
    localparam int CELL_INDEX_W = 11;
    localparam int CELL_W       = 16;
    localparam int CURSOR_COL_W = 7;
    localparam int CURSOR_ROW_W = 5;
    localparam int COLOR_W      = 4;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Special characters
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // Register indexes (paddr bit 2)
    localparam logic REG_BG = 1'b0;
    localparam logic REG_FG = 1'b1;

    // Register reset values
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;
    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;

    // Input item
    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [CHAR_W-1:0]       char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
    } t_item;

    // Result item
    typedef struct packed {
        logic [CELL_W-1:0]       read_data;
        logic [CURSOR_COL_W-1:0] cursor_column;
        logic [CURSOR_ROW_W-1:0] cursor_row;
    } t_result;

    // Colors from the register file
    typedef struct packed {
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] fg;
    } t_cfg;

    // What a sweep over the cell store writes
    typedef enum logic [1:0] {
        SWEEP_ZERO   = 2'd0,
        SWEEP_BLANK  = 2'd1,
        SWEEP_SCROLL = 2'd2
    } t_sweep;

    // Controller to datapath
    typedef struct packed {
        logic   load_item;
        logic   sweep_start;
        t_sweep sweep_kind;
        logic   sweep_step;
        logic   read_cell;
        logic   put_exec;
        logic   finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scroll_pending;
        logic sweep_last;
    } t_status;

endpackage

FILE: rtl/core/tcw_regs.sv
// ----------------------------------------------------------------------------
// Text console writer register file
// APB-style color registers: background at 0x0, foreground at 0x4.
// ----------------------------------------------------------------------------
module tcw_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output tcw_pkg::t_cfg                o_cfg
);
    import tcw_pkg::*;

    logic [COLOR_W-1:0] r_bg;
    logic [COLOR_W-1:0] r_fg;
    logic               wr_xfer;

    // Write transfer completes in the access phase
    assign wr_xfer = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg <= BG_RESET;
            r_fg <= FG_RESET;
        end else if (wr_xfer) begin
            if (paddr[2] == REG_BG) begin
                r_bg <= pwdata[COLOR_W-1:0];
            end else begin
                r_fg <= pwdata[COLOR_W-1:0];
            end
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_FG) begin
            prdata[COLOR_W-1:0] = r_fg;
        end else begin
            prdata[COLOR_W-1:0] = r_bg;
        end
    end

    assign o_cfg.bg = r_bg;
    assign o_cfg.fg = r_fg;

endmodule

FILE: rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console writer controller
// One-hot sequencer for reset clearing, put, scroll, clear and read.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tcw_pkg::MODE_W-1:0]  i_mode,
    input  tcw_pkg::t_status            i_status,
    output tcw_pkg::t_cmd               o_cmd,
    output logic                        o_busy
);
    import tcw_pkg::*;

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_SCROLL = 8'b0000_0100,
        ST_DRAIN  = 8'b0000_1000,
        ST_CLEAR  = 8'b0001_0000,
        ST_PUT    = 8'b0010_0000,
        ST_READ   = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load_item = 1'b1;
                    unique case (i_mode)
                        MODE_PUT: begin
                            if (i_status.scroll_pending) begin
                                o_cmd.sweep_start = 1'b1;
                                o_cmd.sweep_kind  = SWEEP_SCROLL;
                                n_state           = ST_SCROLL;
                            end else begin
                                n_state = ST_PUT;
                            end
                        end
                        MODE_CLEAR: begin
                            o_cmd.sweep_start = 1'b1;
                            o_cmd.sweep_kind  = SWEEP_BLANK;
                            n_state           = ST_CLEAR;
                        end
                        MODE_READ: begin
                            n_state = ST_READ;
                        end
                        default: begin
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCROLL: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = ST_DRAIN;
                end
            end
            // last copy write still in flight: keep the write port free
            ST_DRAIN: begin
                n_state = ST_PUT;
            end
            ST_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_PUT: begin
                o_cmd.put_exec = 1'b1;
                o_cmd.finish   = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_READ: begin
                o_cmd.read_cell = 1'b1;
                n_state         = ST_FINISH;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

FILE: rtl/core/tcw_datapath.sv
// ----------------------------------------------------------------------------
// Text console writer datapath
// Cell store, cursor, sweep pipeline and result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcw_pkg::t_item     i_item,
    input  tcw_pkg::t_cfg      i_cfg,
    input  tcw_pkg::t_cmd      i_cmd,
    output tcw_pkg::t_status   o_status,
    output tcw_pkg::t_result   o_result,
    output logic               o_done
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int LW    = $clog2(ROWS + 1);

    // Cell store
    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;

    // Latched item
    logic [MODE_W-1:0] r_mode;
    logic [CHAR_W-1:0] r_char;
    logic [AW-1:0]     r_index;
    logic              r_index_ok;

    // Cursor
    logic [CW-1:0] r_col;
    logic [LW-1:0] r_line;
    logic [CW-1:0] n_col;
    logic [LW-1:0] n_line;
    logic [CW:0]   col_inc;

    // Sweep: stage 1 reads the source, stage 2 writes the destination
    t_sweep        r_kind;
    logic [AW-1:0] r_cnt;
    logic          r_wr_pend;
    logic [AW-1:0] r_wr_addr;
    logic          r_wr_copy;
    logic [AW:0]   sweep_src;
    logic          copy_ok;

    // Memory ports
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [CELL_W-1:0] blank;
    logic [CELL_W-1:0] sweep_data;
    logic [31:0]       put_addr_full;
    logic              printable;

    // Output register
    logic    r_done;
    t_result r_result;

    assign blank     = {i_cfg.bg, i_cfg.bg, CHAR_SPACE};
    assign printable = (r_char[7] == 1'b0) && (r_char[6:5] != 2'b00);

    // Item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode     <= i_item.mode;
            r_char     <= i_item.char_code;
            r_index    <= AW'(i_item.cell_index);
            r_index_ok <= (32'(i_item.cell_index) < 32'(CELLS));
        end
    end

    // Sweep counter and stage 2 control
    assign sweep_src = {1'b0, r_cnt} + (AW+1)'(COLUMNS);
    assign copy_ok   = (r_kind == SWEEP_SCROLL) && (sweep_src < (AW+1)'(CELLS));

    assign o_status.sweep_last     = (r_cnt == AW'(CELLS - 1));
    assign o_status.scroll_pending = (r_line == LW'(ROWS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= SWEEP_ZERO;
            r_cnt     <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.sweep_step;
            if (i_cmd.sweep_start) begin
                r_kind <= i_cmd.sweep_kind;
                r_cnt  <= '0;
            end else if (i_cmd.sweep_step) begin
                r_cnt <= AW'({1'b0, r_cnt} + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_step) begin
            r_wr_addr <= r_cnt;
            r_wr_copy <= copy_ok;
        end
    end

    // Read port select
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_cnt;
        if (i_cmd.sweep_step) begin
            rd_en   = copy_ok;
            rd_addr = copy_ok ? sweep_src[AW-1:0] : r_cnt;
        end else if (i_cmd.read_cell) begin
            rd_en   = r_index_ok;
            rd_addr = r_index_ok ? r_index : '0;
        end
    end

    // Write port select: sweep writes and put writes never share a cycle
    assign put_addr_full = 32'(r_line) * 32'(COLUMNS) + 32'(r_col);

    always_comb begin
        unique case (r_kind)
            SWEEP_ZERO:   sweep_data = '0;
            SWEEP_BLANK:  sweep_data = blank;
            SWEEP_SCROLL: sweep_data = r_wr_copy ? r_rd_data : blank;
            default:      sweep_data = blank;
        endcase
    end

    always_comb begin
        priority if (r_wr_pend) begin
            wr_en   = 1'b1;
            wr_addr = r_wr_addr;
            wr_data = sweep_data;
        end else begin
            wr_en   = i_cmd.put_exec && printable;
            wr_addr = AW'(put_addr_full);
            wr_data = {i_cfg.bg, i_cfg.fg, r_char};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Cursor update
    assign col_inc = {1'b0, r_col} + 1'b1;

    always_comb begin
        n_col  = r_col;
        n_line = r_line;
        if (i_cmd.sweep_start) begin
            if (i_cmd.sweep_kind == SWEEP_BLANK) begin
                n_col  = '0;
                n_line = '0;
            end else begin
                n_line = LW'(ROWS - 1);
            end
        end else if (i_cmd.put_exec) begin
            priority if (r_char == CHAR_CR) begin
                n_col = '0;
            end else if (r_char == CHAR_LF) begin
                n_col  = '0;
                n_line = LW'({1'b0, r_line} + 1'b1);
            end else if (col_inc == (CW+1)'(COLUMNS)) begin
                n_col  = '0;
                n_line = LW'({1'b0, r_line} + 1'b1);
            end else begin
                n_col = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
        end else begin
            r_col  <= n_col;
            r_line <= n_line;
        end
    end

    // Result register: one strobe per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result.read_data     <= ((r_mode == MODE_READ) && r_index_ok) ? r_rd_data : '0;
            r_result.cursor_column <= CURSOR_COL_W'(n_col);
            r_result.cursor_row    <= CURSOR_ROW_W'(n_line);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Character console with a COLUMNS x ROWS cell store, cursor and scrolling.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; each item gives one
// result on o_result for a single cycle, flagged by o_done, and the receiver
// cannot stall it. After reset busy stays high while the cell store is
// cleared to zero. A put without scroll puts at once; a read reads its
// cell, then finishes; an unused mode 3 just finishes; a clear sweeps
// blanks over the store, then finishes; a put that scrolls first sweeps
// the store, drains the last copy write, then puts. The sweeps walk the
// cell store one cell per cycle. The user must write colors through the
// APB-style port while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item and result transfers
    input  logic                         start,
    output logic                         busy,
    input  tcw_pkg::t_item               i_item,
    output logic                         o_done,
    output tcw_pkg::t_result             o_result,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import tcw_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    tcw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_item.mode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cfg    (cfg),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_result),
        .o_done   (o_done)
    );

    // Checks
    `TCW_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "item not started")
    `TCW_ASSERT_SAME(a_done_after_work, i_clk, i_rst_n, o_done, $past(busy), "result while idle")
    `TCW_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "strobe too long")

endmodule
